/* rtl/csl_pkg.sv */
// shared types and constants of the character stream lexer
package csl_pkg;

   // token kinds, with the code used for "no run open"
   localparam logic [2:0] KIND_COMMENT = 3'd0;
   localparam logic [2:0] KIND_OPER    = 3'd1;
   localparam logic [2:0] KIND_SEP     = 3'd2;
   localparam logic [2:0] KIND_WS      = 3'd3;
   localparam logic [2:0] KIND_LIT     = 3'd4;
   localparam logic [2:0] KIND_IDENT   = 3'd5;
   localparam logic [2:0] KIND_ERROR   = 3'd6;
   localparam logic [2:0] RUN_NONE     = 3'd7;

   // error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_BYTE     = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_LIMIT    = 2'd3;

   // register file
   localparam int         CSR_ADDR_W      = 3;
   localparam logic       REG_TOKEN_LIMIT = 1'b0;
   localparam logic [15:0] TOKEN_LIMIT_RESET = 16'hFFFF;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  sym;
      logic [62:0] lit_value;
      logic [15:0] tok_row;
      logic [15:0] tok_col;
      logic [15:0] tok_len;
      logic [1:0]  err_code;
      logic        last;
   } csl_result_type;

   // results produced by one input byte, first in order first
   typedef struct packed {
      logic [1:0]     count;
      csl_result_type first;
      csl_result_type second;
   } csl_push_type;

endpackage

/* rtl/char_stream_lexer_core.sv */
// top level of the byte-serial lexer: input register, csr, lexer and result queue
// path: a byte waits in the input register until the queue has room for two results; its
//   results are then written to the result queue, whose head is shown on rsp
// throughput: one byte per cycle while rsp is ready and each byte gives at most one result;
//   a byte that closes a run and makes its own token gives two, and the single rsp port drains them one a cycle
// reset: synchronous, active high; row 1, column 0, no run, running, queue empty, limit 65535
module char_stream_lexer_core import csl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // ch [7:0]
   input  logic                  req_tlast,   // end_of_input
   // token results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sym [7:0], lit_value [70:8], tok_row [86:71], tok_col [102:87],
   // tok_len [118:103], err_code [120:119], zero fill [127:121]
   output logic [127:0]          rsp_tdata,
   output logic [2:0]            rsp_tuser,   // kind [2:0]
   output logic                  rsp_tlast,   // last result of its byte
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_ch_ff;
   logic           in_eoi_ff;
   logic [15:0]    token_limit_ff;
   logic           process, room, take, csr_wr, csr_hit;
   csl_push_type   push;
   csl_result_type head;

   // csr: a single register at byte address zero
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_TOKEN_LIMIT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? {16'd0, token_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         token_limit_ff <= TOKEN_LIMIT_RESET;
      end else if (csr_wr) begin
         token_limit_ff <= csr_pwdata[15:0];
      end
   end

   // input register: the byte is worked on once the queue has room for two results
   assign process    = in_vld_ff && room;
   assign req_tready = !in_vld_ff || process;
   assign take       = req_tvalid && req_tready;
   assign in_vld_in  = take || (in_vld_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_ch_ff  <= req_tdata;
         in_eoi_ff <= req_tlast;
      end
   end

   csl_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (process),
      .ch           (in_ch_ff),
      .end_of_input (in_eoi_ff),
      .token_limit  (token_limit_ff),
      .push         (push)
   );

   csl_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_tready),
      .head     (head),
      .head_vld (rsp_tvalid),
      .room     (room)
   );

   // result transfer fields
   assign rsp_tdata = {7'd0, head.err_code, head.tok_len, head.tok_col, head.tok_row,
                       head.lit_value, head.sym};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

/* rtl/csl_engine.sv */
// lexer state and per-byte token classification
module csl_engine import csl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   ch,
   input  logic         end_of_input,
   input  logic [15:0]  token_limit,
   output csl_push_type push
);

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [62:0] ACC_TOP  = 63'd922337203685477580;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   logic [2:0]  run_kind_ff, run_kind_in;
   logic [15:0] run_col_ff, run_col_in;
   logic [15:0] run_len_ff, run_len_in;
   logic [62:0] accum_ff, accum_in;
   logic        overflowed_ff, overflowed_in;
   logic [15:0] line_number_ff, line_number_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] token_count_ff, token_count_in;
   logic        stopped_ff, stopped_in;

   logic           is_digit, is_letter, is_blank;
   logic           cont, close_vld, close_ovf, limit_hit, cl_emit, own_vld;
   logic           digit_ovf;
   logic [3:0]     digit;
   logic [62:0]    acc_next;
   csl_result_type close_res, own_res;

   assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
   assign is_letter = ((ch >= CH_UA) && (ch <= CH_UZ)) || ((ch >= CH_LA) && (ch <= CH_LZ));
   assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
   assign digit     = ch[3:0];

   // times ten as two shifts and an add
   assign acc_next  = {accum_ff[59:0], 3'b000} + {accum_ff[61:0], 1'b0} + {59'd0, digit};
   assign digit_ovf = (accum_ff > ACC_TOP) || ((accum_ff == ACC_TOP) && (digit > 4'd7));

   assign cont = ((run_kind_ff == KIND_COMMENT) && (ch != CH_LF)) ||
                 ((run_kind_ff == KIND_WS) && is_blank) ||
                 ((run_kind_ff == KIND_LIT) && is_digit) ||
                 ((run_kind_ff == KIND_IDENT) && is_letter);

   assign close_vld = (run_kind_ff != RUN_NONE);
   assign close_ovf = close_vld && (run_kind_ff == KIND_LIT) && overflowed_ff;
   assign limit_hit = (token_count_ff >= token_limit);

   always_comb begin
      close_res.kind      = close_ovf ? KIND_ERROR : run_kind_ff;
      close_res.sym       = 8'd0;
      close_res.lit_value = (!close_ovf && (run_kind_ff == KIND_LIT)) ? accum_ff : 63'd0;
      close_res.tok_row   = line_number_ff;
      close_res.tok_col   = run_col_ff;
      close_res.tok_len   = close_ovf ? 16'd0 : run_len_ff;
      close_res.err_code  = close_ovf ? ERR_OVERFLOW : ERR_OK;
      close_res.last      = 1'b0;
   end

   always_comb begin
      run_kind_in    = run_kind_ff;
      run_col_in     = run_col_ff;
      run_len_in     = run_len_ff;
      accum_in       = accum_ff;
      overflowed_in  = overflowed_ff;
      line_number_in = line_number_ff;
      column_in      = column_ff;
      token_count_in = token_count_ff;
      stopped_in     = stopped_ff;
      cl_emit        = 1'b0;
      own_vld        = 1'b0;

      own_res.kind      = KIND_SEP;
      own_res.sym       = 8'd0;
      own_res.lit_value = 63'd0;
      own_res.tok_row   = line_number_ff;
      own_res.tok_col   = column_ff;
      own_res.tok_len   = 16'd1;
      own_res.err_code  = ERR_OK;
      own_res.last      = 1'b0;

      if (fire && !stopped_ff) begin
         if (end_of_input) begin
            // flush run, then newline or limit error
            cl_emit     = close_vld;
            run_kind_in = RUN_NONE;
            stopped_in  = 1'b1;
            if (!close_ovf) begin
               own_vld = 1'b1;
               if (limit_hit) begin
                  own_res.kind     = KIND_ERROR;
                  own_res.tok_len  = 16'd0;
                  own_res.err_code = ERR_LIMIT;
               end else begin
                  own_res.sym    = CH_LF;
                  token_count_in = sat_inc(token_count_ff);
               end
            end
         end else if (cont) begin
            run_len_in = sat_inc(run_len_ff);
            column_in  = sat_inc(column_ff);
            if ((run_kind_ff == KIND_LIT) && !overflowed_ff) begin
               if (digit_ovf) begin
                  overflowed_in = 1'b1;
               end else begin
                  accum_in = acc_next;
               end
            end
         end else begin
            cl_emit     = close_vld;
            run_kind_in = RUN_NONE;
            if (close_ovf) begin
               stopped_in = 1'b1;
            end else if (limit_hit) begin
               own_vld          = 1'b1;
               own_res.kind     = KIND_ERROR;
               own_res.tok_len  = 16'd0;
               own_res.err_code = ERR_LIMIT;
               stopped_in       = 1'b1;
            end else begin
               token_count_in = sat_inc(token_count_ff);
               column_in      = sat_inc(column_ff);
               case (ch) inside
                  CH_HASH, CH_SPACE, CH_TAB, [CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]: begin
                     // opens a run
                     run_col_in    = column_ff;
                     run_len_in    = 16'd1;
                     overflowed_in = 1'b0;
                     accum_in      = is_digit ? {59'd0, digit} : 63'd0;
                     if (ch == CH_HASH) begin
                        run_kind_in = KIND_COMMENT;
                     end else if (is_blank) begin
                        run_kind_in = KIND_WS;
                     end else if (is_digit) begin
                        run_kind_in = KIND_LIT;
                     end else begin
                        run_kind_in = KIND_IDENT;
                     end
                  end
                  CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
                     own_vld      = 1'b1;
                     own_res.kind = KIND_OPER;
                     own_res.sym  = ch;
                  end
                  CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA: begin
                     own_vld     = 1'b1;
                     own_res.sym = ch;
                  end
                  CH_LF: begin
                     own_vld        = 1'b1;
                     own_res.sym    = CH_LF;
                     line_number_in = sat_inc(line_number_ff);
                     column_in      = 16'd0;
                  end
                  default: begin
                     own_vld          = 1'b1;
                     own_res.kind     = KIND_ERROR;
                     own_res.tok_len  = 16'd0;
                     own_res.err_code = ERR_BYTE;
                     column_in        = column_ff;
                     stopped_in       = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      push.count       = {1'b0, cl_emit} + {1'b0, own_vld};
      push.first       = cl_emit ? close_res : own_res;
      push.first.last  = (push.count == 2'd1);
      push.second      = own_res;
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff    <= RUN_NONE;
         run_col_ff     <= 16'd0;
         run_len_ff     <= 16'd0;
         accum_ff       <= 63'd0;
         overflowed_ff  <= 1'b0;
         line_number_ff <= 16'd1;
         column_ff      <= 16'd0;
         token_count_ff <= 16'd0;
         stopped_ff     <= 1'b0;
      end else begin
         run_kind_ff    <= run_kind_in;
         run_col_ff     <= run_col_in;
         run_len_ff     <= run_len_in;
         accum_ff       <= accum_in;
         overflowed_ff  <= overflowed_in;
         line_number_ff <= line_number_in;
         column_ff      <= column_in;
         token_count_ff <= token_count_in;
         stopped_ff     <= stopped_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (push.count == 2'd0))
      else $error("results pushed while stopped");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(column_ff) && $stable(token_count_ff) && $stable(run_kind_ff)))
      else $error("lexer state moved without a byte");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> ((push.first.err_code == ERR_OK) && !push.first.last))
      else $error("bad first result of a pair");
`endif

endmodule

/* rtl/csl_rsp_fifo.sv */
// small result queue that takes up to two results per cycle
module csl_rsp_fifo import csl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  csl_push_type   push,
   input  logic           pop,
   output csl_result_type head,
   output logic           head_vld,
   output logic           room
);

   csl_result_type          mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]    count_ff, count_in;
   logic [RSP_CNT_W-1:0]    count_left;
   logic                    do_pop;

   assign head_vld   = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_vld;
   assign count_left = count_ff - {{(RSP_CNT_W-1){1'b0}}, do_pop};
   // room for two more after this cycle's pop
   assign room       = (count_left <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + {{(RSP_PTR_W-1){1'b0}}, do_pop};
   assign count_in  = count_left + RSP_CNT_W'(push.count);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
